FILE: rtl/lz78de_pkg.sv
// ----------------------------------------------------------------------------
// lz78de_pkg
// Shared constants, item and token types, and engine states of the encoder.
// ----------------------------------------------------------------------------
package lz78de_pkg;

	localparam int DICT_ENTRIES  = 1024;
	localparam int ALPHABET_SIZE = 256;
	localparam int BYTE_W        = $clog2(ALPHABET_SIZE);
	localparam int NODE_W        = $clog2(DICT_ENTRIES);
	localparam int PHRASE_W      = NODE_W + 1;
	localparam int ADDR_W        = NODE_W + BYTE_W;
	localparam int TABLE_SIZE    = DICT_ENTRIES * ALPHABET_SIZE;
	localparam int TDATA_W       = ((NODE_W + BYTE_W + 7) / 8) * 8;
	localparam int TUSER_W       = 2;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [NODE_W-1:0] LIMIT_RESET = NODE_W'(DICT_ENTRIES - 1);

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0] prefix_phrase;
		logic [BYTE_W-1:0] literal_byte;
		logic              has_literal;
		logic              end_of_stream;
		logic              dictionary_full;
	} token_t;

	typedef enum logic [1:0] {
		ENG_CLEAR,
		ENG_READ,
		ENG_DECIDE
	} eng_state_t;

endpackage

FILE: rtl/lz78de_front.sv
// ----------------------------------------------------------------------------
// lz78de_front
// Input side: takes byte beats from the stream and holds them in a short
// queue so the lookup engine can stall on its own.
// ----------------------------------------------------------------------------
module lz78de_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lz78de_pkg::BYTE_W-1:0]    s_axis_tdata,
	input  logic                             s_axis_tlast,
	input  logic                             hold,
	output lz78de_pkg::item_t                item,
	output logic                             item_valid,
	input  logic                             item_pop
);

	lz78de_pkg::item_t                  queue_q [lz78de_pkg::QUEUE_DEPTH];
	logic [lz78de_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lz78de_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lz78de_pkg::QCNT_W-1:0]      count_q;
	logic                               push;
	logic                               pop;

	assign s_axis_tready = (count_q != lz78de_pkg::QCNT_W'(lz78de_pkg::QUEUE_DEPTH)) && !hold;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign item_valid    = (count_q != '0);
	assign pop           = item_pop && item_valid;
	assign item          = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{data_byte: s_axis_tdata, last_byte: s_axis_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lz78de_pkg::QPTR_W'(lz78de_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lz78de_pkg::QPTR_W'(lz78de_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/lz78de_back.sv
// ----------------------------------------------------------------------------
// lz78de_back
// Lookup engine: child table memory, running match node, phrase counter,
// token generation and the output register.
// ----------------------------------------------------------------------------
module lz78de_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lz78de_pkg::NODE_W-1:0]    cfg_wdata,
	input  lz78de_pkg::item_t                item,
	input  logic                             item_valid,
	output logic                             item_pop,
	output logic                             clearing,
	output lz78de_pkg::token_t               tok,
	output logic                             tok_valid,
	input  logic                             tok_ready
);

	lz78de_pkg::eng_state_t              state_q;
	lz78de_pkg::eng_state_t              state_d;

	logic [lz78de_pkg::NODE_W-1:0]       child_mem [lz78de_pkg::TABLE_SIZE];
	logic [lz78de_pkg::NODE_W-1:0]       rd_data_q;
	logic [lz78de_pkg::ADDR_W-1:0]       clr_addr_q;
	logic [lz78de_pkg::NODE_W-1:0]       match_q;
	logic [lz78de_pkg::PHRASE_W-1:0]     next_phrase_q;
	logic [lz78de_pkg::NODE_W-1:0]       limit_q;
	logic [lz78de_pkg::BYTE_W-1:0]       byte_q;
	logic                                last_q;
	lz78de_pkg::token_t                  tok_q;
	logic                                tok_valid_q;

	logic                                mem_we;
	logic [lz78de_pkg::ADDR_W-1:0]       mem_waddr;
	logic [lz78de_pkg::NODE_W-1:0]       mem_wdata;
	logic                                mem_re;
	logic                                hit;
	logic                                can_add;
	logic                                need_out;
	logic                                out_free;
	logic                                fire;

	assign hit      = (rd_data_q != '0);
	assign can_add  = (next_phrase_q <= {1'b0, limit_q})
		&& (next_phrase_q < lz78de_pkg::PHRASE_W'(lz78de_pkg::DICT_ENTRIES));
	assign need_out = !hit || last_q;
	assign out_free = !tok_valid_q || tok_ready;

	assign clearing  = (state_q == lz78de_pkg::ENG_CLEAR);
	assign tok       = tok_q;
	assign tok_valid = tok_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lz78de_pkg::ENG_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		item_pop  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {match_q, byte_q};
		mem_wdata = next_phrase_q[lz78de_pkg::NODE_W-1:0];
		fire      = 1'b0;
		unique case (state_q)
			lz78de_pkg::ENG_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
				if (clr_addr_q == '1) begin
					state_d = lz78de_pkg::ENG_READ;
				end
			end
			lz78de_pkg::ENG_READ: begin
				if (item_valid) begin
					item_pop = 1'b1;
					mem_re   = 1'b1;
					state_d  = lz78de_pkg::ENG_DECIDE;
				end
			end
			lz78de_pkg::ENG_DECIDE: begin
				// a token must find the output register free, a plain extend never waits
				if (!need_out || out_free) begin
					fire    = 1'b1;
					mem_we  = !hit && can_add;
					state_d = lz78de_pkg::ENG_READ;
				end
			end
			default: begin
				state_d = lz78de_pkg::ENG_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			child_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= child_mem[{match_q, item.data_byte}];
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			byte_q <= item.data_byte;
			last_q <= item.last_byte;
		end
		if (fire && need_out && out_free) begin
			if (hit) begin
				tok_q <= '{prefix_phrase: rd_data_q, literal_byte: '0, has_literal: 1'b0,
					end_of_stream: 1'b1, dictionary_full: 1'b0};
			end else begin
				tok_q <= '{prefix_phrase: match_q, literal_byte: byte_q, has_literal: 1'b1,
					end_of_stream: last_q, dictionary_full: !can_add};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			match_q       <= '0;
			next_phrase_q <= lz78de_pkg::PHRASE_W'(1);
			limit_q       <= lz78de_pkg::LIMIT_RESET;
			tok_valid_q   <= 1'b0;
		end else begin
			if (state_q == lz78de_pkg::ENG_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (fire) begin
				match_q <= (hit && !last_q) ? rd_data_q : '0;
				if (!hit && can_add) begin
					next_phrase_q <= next_phrase_q + 1'b1;
				end
			end
			if (fire && need_out) begin
				tok_valid_q <= 1'b1;
			end else if (tok_ready) begin
				tok_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/lz78_dictionary_encoder_unit.sv
// ----------------------------------------------------------------------------
// lz78_dictionary_encoder_unit
// LZ78 encoder: parses a byte stream into (prefix phrase, byte) tokens.
//
// In the lookup engine each byte passes ENG_READ, the registered read of the
// child table at (match node, byte), then ENG_DECIDE, which decides, writes
// a new phrase and moves the match node that the next byte's read depends on.
// A 2-beat queue in front keeps taking bytes while the engine or the output
// waits, and the token register lets the engine go on while a token is held
// by the sink. After reset the child table (1024 x 256 entries) is swept to
// zero, one entry a cycle; s_axis_tready stays low during the sweep, while
// cfg_we is taken as usual. A byte that extends the match gives
// no token; the last byte of a stream always gives one (a prefix-only flush
// token with tuser[0] low when the match still extends).
// ----------------------------------------------------------------------------
module lz78_dictionary_encoder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lz78de_pkg::NODE_W-1:0]      cfg_wdata,     // phrase_limit
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lz78de_pkg::BYTE_W-1:0]      s_axis_tdata,  // data_byte
	input  logic                               s_axis_tlast,  // last_byte
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lz78de_pkg::TDATA_W-1:0]     m_axis_tdata,  // prefix_phrase, literal_byte, zero pad
	output logic [lz78de_pkg::TUSER_W-1:0]     m_axis_tuser,  // has_literal, dictionary_full
	output logic                               m_axis_tlast   // end_of_stream
);

	lz78de_pkg::item_t   item;
	logic                item_valid;
	logic                item_pop;
	logic                clearing;
	lz78de_pkg::token_t  tok;

	lz78de_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.hold          (clearing),
		.item          (item),
		.item_valid    (item_valid),
		.item_pop      (item_pop)
	);

	lz78de_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.clearing   (clearing),
		.tok        (tok),
		.tok_valid  (m_axis_tvalid),
		.tok_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {
		(lz78de_pkg::TDATA_W - lz78de_pkg::NODE_W - lz78de_pkg::BYTE_W)'(0),
		tok.literal_byte,
		tok.prefix_phrase
	};
	assign m_axis_tuser = {tok.dictionary_full, tok.has_literal};
	assign m_axis_tlast = tok.end_of_stream;

endmodule

FILE: rtl/lz78de_checker.sv
// ----------------------------------------------------------------------------
// lz78de_checker
// Port-level checks on the encoder's token stream, bound to the top level.
// ----------------------------------------------------------------------------
module lz78de_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [lz78de_pkg::TDATA_W-1:0]     m_axis_tdata,
	input  logic [lz78de_pkg::TUSER_W-1:0]     m_axis_tuser,
	input  logic                               m_axis_tlast
);

	// a stalled token beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("token beat changed while stalled");

	// a flush token only ends a stream and never reports a full dictionary
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1])
		else $error("flush token without end of stream");

	// a flush token carries no literal
	a_flush_lit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[lz78de_pkg::NODE_W+lz78de_pkg::BYTE_W-1:lz78de_pkg::NODE_W] == '0)
		else $error("flush token with nonzero literal");

	// a flush token names a real phrase, never the root
	a_flush_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[lz78de_pkg::NODE_W-1:0] != '0)
		else $error("flush token points at the root");

endmodule

bind lz78_dictionary_encoder_unit lz78de_checker u_lz78de_checker (.*);

FILE: tb/lz78_dictionary_encoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz78_dictionary_encoder_unit_test
// Self-checking bench for the LZ78 encoder. Byte streams go in on the slave
// stream; each output token is checked field by field against the script or
// a running phrase parser kept here. A short scripted stream comes first, then
// random streams under several phrase limits and handshake idling patterns.
// ----------------------------------------------------------------------------
module lz78_dictionary_encoder_unit_test;

	localparam int CYCLE_LIMIT  = 1500000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_SILENT,
		ROW_TOKEN
	} row_kind_t;

	typedef struct packed {
		logic [lz78de_pkg::BYTE_W-1:0] data_b;
		logic                          last_b;
		row_kind_t                     kind;
		lz78de_pkg::token_t            tok;
	} script_row_t;

	// token fields: prefix, literal, has_literal, end_of_stream, dictionary_full
	localparam int SCRIPT_LEN = 21;
	localparam script_row_t OPENING_SCRIPT [SCRIPT_LEN] = '{
		{8'h00, 1'b0, ROW_TOKEN,   {10'd0, 8'h00, 1'b1, 1'b0, 1'b0}},
		{8'hFF, 1'b0, ROW_TOKEN,   {10'd0, 8'hFF, 1'b1, 1'b0, 1'b0}},
		{8'h00, 1'b0, ROW_SILENT,  {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFF, 1'b0, ROW_TOKEN,   {10'd1, 8'hFF, 1'b1, 1'b0, 1'b0}},
		{8'h00, 1'b1, ROW_TOKEN,   {10'd1, 8'h00, 1'b0, 1'b1, 1'b0}},
		{8'hFF, 1'b1, ROW_TOKEN,   {10'd2, 8'h00, 1'b0, 1'b1, 1'b0}},
		{8'hAB, 1'b1, ROW_TOKEN,   {10'd0, 8'hAB, 1'b1, 1'b1, 1'b0}},
		{8'h00, 1'b0, ROW_SILENT,  {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFF, 1'b0, ROW_SILENT,  {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h55, 1'b1, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h00, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFF, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h55, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h55, 1'b1, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h80, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h01, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h7F, 1'b1, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'h80, 1'b1, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFE, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFE, 1'b0, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}},
		{8'hFE, 1'b1, ROW_PREDICT, {10'd0, 8'h00, 1'b0, 1'b0, 1'b0}}
	};

	// four byte values picked with a per-stream likelihood so that phrases grow long
	localparam logic [lz78de_pkg::BYTE_W-1:0] NARROW_SET [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lz78de_pkg::NODE_W-1:0]   cfg_wdata;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [lz78de_pkg::BYTE_W-1:0]   s_axis_tdata;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [lz78de_pkg::TDATA_W-1:0]  m_axis_tdata;
	logic [lz78de_pkg::TUSER_W-1:0]  m_axis_tuser;
	logic                            m_axis_tlast;

	// phrase parser state
	bit   [lz78de_pkg::NODE_W-1:0]   child_phrase [lz78de_pkg::TABLE_SIZE];
	logic [lz78de_pkg::NODE_W-1:0]   match_at     = '0;
	logic [lz78de_pkg::PHRASE_W-1:0] phrase_next  = lz78de_pkg::PHRASE_W'(1);
	logic [lz78de_pkg::NODE_W-1:0]   phrase_limit = lz78de_pkg::LIMIT_RESET;

	lz78de_pkg::token_t tokens_due [$];

	int  snd_idle_pct = 0;
	int  rcv_idle_pct = 0;
	bit  hold_req     = 1'b0;
	int  hold_left    = 0;
	int  check_errors = 0;
	int  cycle_count  = 0;
	int  bytes_sent   = 0;
	int  tokens_seen  = 0;
	int  flush_seen   = 0;
	int  frozen_seen  = 0;

	lz78_dictionary_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one byte through the phrase parser; returns 1 when a token comes out
	function automatic bit parse_byte(input logic [lz78de_pkg::BYTE_W-1:0] b, input logic l,
			output lz78de_pkg::token_t tok);
		logic [lz78de_pkg::ADDR_W-1:0] slot;
		logic [lz78de_pkg::NODE_W-1:0] child;
		slot  = {match_at, b};
		child = child_phrase[slot];
		tok   = '0;
		if (child != '0) begin
			match_at = child;
			if (!l) return 1'b0;
			// stream ends inside a known phrase: prefix-only flush
			tok.prefix_phrase = child;
			tok.end_of_stream = 1'b1;
			match_at          = '0;
			return 1'b1;
		end
		tok.dictionary_full = 1'b1;
		if (phrase_next <= {1'b0, phrase_limit} && phrase_next < lz78de_pkg::DICT_ENTRIES) begin
			child_phrase[slot]  = phrase_next[lz78de_pkg::NODE_W-1:0];
			phrase_next         = phrase_next + 1'b1;
			tok.dictionary_full = 1'b0;
		end
		tok.prefix_phrase = match_at;
		tok.literal_byte  = b;
		tok.has_literal   = 1'b1;
		tok.end_of_stream = l;
		match_at          = '0;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [lz78de_pkg::BYTE_W-1:0] b, input logic l,
			input row_kind_t kind, input lz78de_pkg::token_t typed);
		int                 gap;
		lz78de_pkg::token_t tok;
		bit                 got;
		if ($urandom_range(99) < snd_idle_pct) begin
			gap = $urandom_range(3, 1);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		got = parse_byte(b, l, tok);
		case (kind)
			ROW_PREDICT: begin
				if (got) tokens_due.push_back(tok);
			end
			ROW_TOKEN: begin
				tokens_due.push_back(typed);
			end
			default: begin
			end
		endcase
		bytes_sent++;
	endtask

	task automatic random_stream(input int n, input int narrow_pct);
		logic [lz78de_pkg::BYTE_W-1:0] b;
		logic                          l;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < narrow_pct)
				b = NARROW_SET[$urandom_range(3)];
			else
				b = lz78de_pkg::BYTE_W'($urandom);
			l = ($urandom_range(24) == 0);
			send_byte(b, l, ROW_PREDICT, '0);
		end
	endtask

	// stop offering, let every token out, then give silent bytes time to finish
	task automatic settle;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [lz78de_pkg::NODE_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		phrase_limit = v;
	endtask

	// sink side: random stalls plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		lz78de_pkg::token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			tokens_seen++;
			if (!m_axis_tuser[0]) flush_seen++;
			if (m_axis_tuser[1]) frozen_seen++;
			if (tokens_due.size() == 0) begin
				$error("token beat with nothing expected: tdata=%h tuser=%b tlast=%b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				check_errors++;
			end else begin
				want = tokens_due.pop_front();
				if (m_axis_tdata[lz78de_pkg::NODE_W-1:0] !== want.prefix_phrase) begin
					$error("prefix_phrase: expected %0d, got %0d",
						want.prefix_phrase, m_axis_tdata[lz78de_pkg::NODE_W-1:0]);
					check_errors++;
				end
				if (m_axis_tdata[lz78de_pkg::NODE_W+lz78de_pkg::BYTE_W-1:lz78de_pkg::NODE_W]
						!== want.literal_byte) begin
					$error("literal_byte: expected %h, got %h", want.literal_byte,
						m_axis_tdata[lz78de_pkg::NODE_W+lz78de_pkg::BYTE_W-1:lz78de_pkg::NODE_W]);
					check_errors++;
				end
				if (m_axis_tuser[0] !== want.has_literal) begin
					$error("has_literal: expected %b, got %b",
						want.has_literal, m_axis_tuser[0]);
					check_errors++;
				end
				if (m_axis_tlast !== want.end_of_stream) begin
					$error("end_of_stream: expected %b, got %b",
						want.end_of_stream, m_axis_tlast);
					check_errors++;
				end
				if (m_axis_tuser[1] !== want.dictionary_full) begin
					$error("dictionary_full: expected %b, got %b",
						want.dictionary_full, m_axis_tuser[1]);
					check_errors++;
				end
			end
		end
	end

	// the clearing sweep after reset dominates the cycle budget
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d tokens outstanding",
				cycle_count, tokens_due.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int lim;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles a little, sink a lot
		snd_idle_pct = 11;
		rcv_idle_pct = 70;
		write_limit(10'd1023);
		for (int r = 0; r < SCRIPT_LEN; r++)
			send_byte(OPENING_SCRIPT[r].data_b, OPENING_SCRIPT[r].last_b,
				OPENING_SCRIPT[r].kind, OPENING_SCRIPT[r].tok);
		random_stream(300, 60);
		settle();

		// roles swapped; dictionary frozen by a low limit, then by a zero limit
		snd_idle_pct = 70;
		rcv_idle_pct = 11;
		write_limit(10'd1);
		random_stream(80, 60);
		settle();
		write_limit(10'd0);
		random_stream(80, 60);
		settle();

		// limit just above the current phrase count, so it freezes mid-stream
		lim = int'(phrase_next) + 25;
		if (lim > 1023) lim = 1023;
		write_limit(lz78de_pkg::NODE_W'(lim));
		snd_idle_pct = 0;
		hold_req     = 1'b1;
		random_stream(200, 20);
		settle();

		// no idling on either side, dictionary resumes growing
		rcv_idle_pct = 0;
		write_limit(10'd1023);
		random_stream(420, 50);
		settle();

		$display("sent %0d bytes, checked %0d tokens (%0d flush, %0d with dictionary full)",
			bytes_sent, tokens_seen, flush_seen, frozen_seen);
		$display("phrase limits 1023, 1, 0, %0d; %0d phrases in the dictionary at the end",
			lim, int'(phrase_next) - 1);
		if (check_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/lz78de_pkg.sv
rtl/lz78de_front.sv
rtl/lz78de_back.sv
rtl/lz78_dictionary_encoder_unit.sv
rtl/lz78de_checker.sv
tb/lz78_dictionary_encoder_unit_test.sv
